// File: rtl/bae_pkg.sv
// Shared constants, types and codes of the binary arithmetic encoder.
`default_nettype none
package bae_pkg;

    localparam int PREC_BITS = 31;
    localparam int PROB_BITS = 16;
    localparam int CTX_MAX   = 256;
    localparam int PEND_MAX  = 255;

    localparam int LEN_W   = 9;
    localparam int POS_W   = 8;
    localparam int CNT_W   = 9;
    localparam int PEND_W  = 8;
    localparam int RANGE_W = PREC_BITS + 1;
    localparam int PROD_W  = RANGE_W + PROB_BITS;

    localparam logic [PREC_BITS-1:0] HALF    = PREC_BITS'(1) << (PREC_BITS - 1);
    localparam logic [PREC_BITS-1:0] QUARTER = PREC_BITS'(1) << (PREC_BITS - 2);
    localparam logic [PREC_BITS-1:0] THREE_Q = PREC_BITS'(3) << (PREC_BITS - 2);
    localparam logic [PROB_BITS:0]   PROB_SCALE = (PROB_BITS + 1)'(1) << PROB_BITS;
    localparam logic [LEN_W-1:0]     CTX_CAP = LEN_W'(CTX_MAX);
    localparam logic [PEND_W-1:0]    PEND_LIMIT = PEND_W'(PEND_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NARROW,
        ST_RENORM,
        ST_EMIT,
        ST_FLUSH,
        ST_STATUS
    } state_t;

    typedef enum logic [2:0] {
        ROP_NONE,
        ROP_LOAD,
        ROP_MUL,
        ROP_NARROW,
        ROP_SHIFT,
        ROP_CLEAR
    } rop_t;

    typedef enum logic [1:0] {
        RN_LOW,
        RN_HIGH,
        RN_MID,
        RN_DONE
    } rn_class_t;

    typedef struct packed {
        rn_class_t rclass;
        logic      below_quarter;
    } range_stat_t;

    typedef struct packed {
        logic             emit;
        logic             ebit;
        logic             flush;
        logic             status;
        logic [CNT_W-1:0] ones;
        logic             ovf;
    } pk_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic slot_free;
        logic has_bits;
    } pk_stat_t;

endpackage
`default_nettype wire

// File: rtl/bae_range_unit.sv
// Interval datapath: range multiply, narrowing and one renormalization shift per cycle of ROP_SHIFT.
`default_nettype none
module bae_range_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bae_pkg::rop_t                 rop,
    input  wire logic                          bit_in,
    input  wire logic [bae_pkg::PROB_BITS-1:0] p0_in,
    output bae_pkg::range_stat_t               stat
);

    logic [bae_pkg::PREC_BITS-1:0] low_reg, low_next;
    logic [bae_pkg::PREC_BITS-1:0] high_reg, high_next;
    logic [bae_pkg::RANGE_W-1:0]   range_reg;
    logic [bae_pkg::PROD_W-1:0]    prod_reg;
    logic [bae_pkg::PROB_BITS-1:0] p0_reg;
    logic                          bit_reg;
    logic [bae_pkg::PREC_BITS-1:0] split;
    logic [bae_pkg::PREC_BITS-1:0] split_nz;
    logic [bae_pkg::PREC_BITS-1:0] low_src, high_src;

    assign split    = prod_reg[bae_pkg::PROB_BITS +: bae_pkg::PREC_BITS];
    assign split_nz = (split == '0) ? bae_pkg::PREC_BITS'(1) : split;

    always_comb
    begin
        if (high_reg < bae_pkg::HALF)
            stat.rclass = bae_pkg::RN_LOW;
        else if (low_reg >= bae_pkg::HALF)
            stat.rclass = bae_pkg::RN_HIGH;
        else if (low_reg >= bae_pkg::QUARTER && high_reg < bae_pkg::THREE_Q)
            stat.rclass = bae_pkg::RN_MID;
        else
            stat.rclass = bae_pkg::RN_DONE;
        stat.below_quarter = (low_reg < bae_pkg::QUARTER);
    end

    // Middle case drops a quarter first; the other cases lose the top bit in the shift.
    always_comb
    begin
        if (stat.rclass == bae_pkg::RN_MID)
        begin
            low_src  = low_reg - bae_pkg::QUARTER;
            high_src = high_reg - bae_pkg::QUARTER;
        end
        else
        begin
            low_src  = low_reg;
            high_src = high_reg;
        end
    end

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        unique case (rop)
            bae_pkg::ROP_NARROW:
            begin
                if (bit_reg)
                    low_next = low_reg + split;
                else
                    high_next = low_reg + split_nz - bae_pkg::PREC_BITS'(1);
            end
            bae_pkg::ROP_SHIFT:
            begin
                low_next  = {low_src[bae_pkg::PREC_BITS-2:0], 1'b0};
                high_next = {high_src[bae_pkg::PREC_BITS-2:0], 1'b1};
            end
            bae_pkg::ROP_CLEAR:
            begin
                low_next  = '0;
                high_next = '1;
            end
            default:
            begin
                low_next  = low_reg;
                high_next = high_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '1;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rop == bae_pkg::ROP_LOAD)
        begin
            range_reg <= {1'b0, high_reg} - {1'b0, low_reg} + bae_pkg::RANGE_W'(1);
            p0_reg    <= p0_in;
            bit_reg   <= bit_in;
        end
        if (rop == bae_pkg::ROP_MUL)
            prod_reg <= range_reg * p0_reg;
    end

endmodule
`default_nettype wire

// File: rtl/bae_context.sv
// Context ring of recent bits with its running count of ones.
`default_nettype none
module bae_context (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [bae_pkg::LEN_W-1:0] ctx_len,
    input  wire logic                      start,
    input  wire logic                      bit_in,
    input  wire logic                      clear,
    output logic                           busy,
    output logic [bae_pkg::CNT_W-1:0]      ones
);

    logic                         mem [bae_pkg::CTX_MAX];
    logic [bae_pkg::CTX_MAX-1:0]  valid_reg;
    logic [bae_pkg::POS_W-1:0]    pos_reg;
    logic [bae_pkg::CNT_W-1:0]    ones_reg;
    logic                         upd_reg;
    logic                         bit_reg;
    logic                         rd_reg;
    logic                         rd_vld_reg;
    logic [bae_pkg::LEN_W-1:0]    cap;
    logic [bae_pkg::POS_W-1:0]    pos_wrap;
    logic [bae_pkg::LEN_W-1:0]    pos_inc;
    logic                         old_bit;
    logic                         do_start;

    assign cap      = (ctx_len > bae_pkg::CTX_CAP) ? bae_pkg::CTX_CAP : ctx_len;
    assign pos_wrap = ({1'b0, pos_reg} >= cap) ? '0 : pos_reg;
    assign pos_inc  = {1'b0, pos_reg} + bae_pkg::LEN_W'(1);
    assign old_bit  = rd_reg & rd_vld_reg;
    assign do_start = start && (cap != '0);
    assign busy     = upd_reg;
    assign ones     = ones_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            pos_reg    <= '0;
            ones_reg   <= '0;
            upd_reg    <= 1'b0;
            bit_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
            pos_reg   <= '0;
            ones_reg  <= '0;
            upd_reg   <= 1'b0;
        end
        else if (do_start)
        begin
            pos_reg    <= pos_wrap;
            bit_reg    <= bit_in;
            rd_vld_reg <= valid_reg[pos_wrap];
            upd_reg    <= 1'b1;
        end
        else if (upd_reg)
        begin
            ones_reg           <= ones_reg + bae_pkg::CNT_W'(bit_reg) - bae_pkg::CNT_W'(old_bit);
            valid_reg[pos_reg] <= 1'b1;
            pos_reg            <= (pos_inc >= cap) ? '0 : pos_inc[bae_pkg::POS_W-1:0];
            upd_reg            <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_start)
            rd_reg <= mem[pos_wrap];
        if (upd_reg && !clear)
            mem[pos_reg] <= bit_reg;
    end

endmodule
`default_nettype wire

// File: rtl/bae_packer.sv
// Bit packer into bytes and the output register for byte and status records.
`default_nettype none
module bae_packer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bae_pkg::pk_cmd_t      cmd,
    output bae_pkg::pk_stat_t          stat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       is_byte,
    output logic [7:0]                 out_byte,
    output logic [bae_pkg::CNT_W-1:0]  ones_in_context,
    output logic                       pending_overflow,
    output logic                       run_end
);

    logic [6:0]                acc_reg, acc_next;
    logic [2:0]                bits_reg, bits_next;
    logic                      valid_reg, valid_next;
    logic                      is_byte_reg, is_byte_next;
    logic [7:0]                byte_reg, byte_next;
    logic [bae_pkg::CNT_W-1:0] ones_reg, ones_next;
    logic                      ovf_reg, ovf_next;
    logic                      end_reg, end_next;
    logic                      slot_free;
    logic                      load;

    assign slot_free      = !valid_reg || out_ready;
    assign stat.slot_free = slot_free;
    assign stat.emit_ok   = (bits_reg != 3'd7) || slot_free;
    assign stat.has_bits  = (bits_reg != 3'd0);

    always_comb
    begin
        acc_next     = acc_reg;
        bits_next    = bits_reg;
        load         = 1'b0;
        is_byte_next = is_byte_reg;
        byte_next    = byte_reg;
        ones_next    = ones_reg;
        ovf_next     = ovf_reg;
        end_next     = end_reg;
        if (cmd.emit)
        begin
            if (bits_reg == 3'd7)
            begin
                load         = 1'b1;
                is_byte_next = 1'b1;
                byte_next    = {acc_reg, cmd.ebit};
                ones_next    = '0;
                ovf_next     = 1'b0;
                end_next     = 1'b0;
                acc_next     = '0;
                bits_next    = '0;
            end
            else
            begin
                acc_next  = {acc_reg[5:0], cmd.ebit};
                bits_next = bits_reg + 3'd1;
            end
        end
        else if (cmd.flush && bits_reg != 3'd0)
        begin
            // pad the partial byte with zeros below the last bit
            load         = 1'b1;
            is_byte_next = 1'b1;
            byte_next    = {1'b0, acc_reg} << (3'd0 - bits_reg);
            ones_next    = '0;
            ovf_next     = 1'b0;
            end_next     = 1'b0;
            acc_next     = '0;
            bits_next    = '0;
        end
        else if (cmd.status)
        begin
            load         = 1'b1;
            is_byte_next = 1'b0;
            byte_next    = '0;
            ones_next    = cmd.ones;
            ovf_next     = cmd.ovf;
            end_next     = 1'b1;
        end
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            bits_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            bits_reg  <= bits_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_byte_reg <= is_byte_next;
        byte_reg    <= byte_next;
        ones_reg    <= ones_next;
        ovf_reg     <= ovf_next;
        end_reg     <= end_next;
    end

    assign out_valid        = valid_reg;
    assign is_byte          = is_byte_reg;
    assign out_byte         = byte_reg;
    assign ones_in_context  = ones_reg;
    assign pending_overflow = ovf_reg;
    assign run_end          = end_reg;

endmodule
`default_nettype wire

// File: rtl/binary_arithmetic_encoder.sv
// Top level: sequencer of the binary arithmetic encoder with follow-bit handling.
// Per accepted bit: range load, multiply, narrowing, then renormalization steps, where a low or high
// step emits its bit and its pending followers; a last bit adds a flush before the status record.
// Input: a new bit is taken only in the idle state, once the status record of the previous bit has
// gone to the packer; the shared range unit and output stalls through the packer hold the flow.
// Reset: rst_n clears the interval, pending count, packer, context ring and ring length register.
`default_nettype none
module binary_arithmetic_encoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bae_pkg::LEN_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_bit,
    input  wire logic [bae_pkg::PROB_BITS-1:0] p_one,
    input  wire logic                          final_bit,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               is_byte,
    output logic [7:0]                         out_byte,
    output logic [bae_pkg::CNT_W-1:0]          ones_in_context,
    output logic                               pending_overflow,
    output logic                               run_end
);

    bae_pkg::state_t             state_reg, state_next;
    logic [bae_pkg::LEN_W-1:0]   ctx_len_reg;
    logic [bae_pkg::PEND_W-1:0]  pending_reg, pending_next;
    logic                        ovf_reg, ovf_next;
    logic                        fin_reg, fin_next;
    logic                        ebit_reg, ebit_next;
    logic                        first_reg, first_next;
    logic                        ret_flush_reg, ret_flush_next;

    bae_pkg::rop_t               rop;
    bae_pkg::range_stat_t        rstat;
    bae_pkg::pk_cmd_t            pcmd;
    bae_pkg::pk_stat_t           pstat;
    logic                        ctx_start;
    logic                        ctx_clear;
    logic                        ctx_busy;
    logic [bae_pkg::CNT_W-1:0]   ctx_ones;
    logic [bae_pkg::PROB_BITS-1:0] p1_clamped;
    logic [bae_pkg::PROB_BITS-1:0] p0;
    logic                        accept;
    logic                        bump;
    logic                        emit_last;

    assign p1_clamped = (p_one == '0) ? bae_pkg::PROB_BITS'(1) : p_one;
    assign p0         = bae_pkg::PROB_BITS'(bae_pkg::PROB_SCALE - {1'b0, p1_clamped});
    assign accept     = in_valid && in_ready;
    assign emit_last  = first_reg ? (pending_reg == '0) : (pending_reg == bae_pkg::PEND_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bae_pkg::ST_IDLE:
                if (in_valid)
                    state_next = bae_pkg::ST_MUL;
            bae_pkg::ST_MUL:
                state_next = bae_pkg::ST_NARROW;
            bae_pkg::ST_NARROW:
                state_next = bae_pkg::ST_RENORM;
            bae_pkg::ST_RENORM:
            begin
                unique case (rstat.rclass)
                    bae_pkg::RN_LOW, bae_pkg::RN_HIGH: state_next = bae_pkg::ST_EMIT;
                    bae_pkg::RN_MID:                   state_next = bae_pkg::ST_RENORM;
                    bae_pkg::RN_DONE:
                        state_next = fin_reg ? bae_pkg::ST_EMIT : bae_pkg::ST_STATUS;
                endcase
            end
            bae_pkg::ST_EMIT:
                if (pstat.emit_ok && emit_last)
                    state_next = ret_flush_reg ? bae_pkg::ST_FLUSH : bae_pkg::ST_RENORM;
            bae_pkg::ST_FLUSH:
                if (pstat.slot_free || !pstat.has_bits)
                    state_next = bae_pkg::ST_STATUS;
            bae_pkg::ST_STATUS:
                if (pstat.slot_free && !ctx_busy)
                    state_next = bae_pkg::ST_IDLE;
            default:
                state_next = bae_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        in_ready       = 1'b0;
        rop            = bae_pkg::ROP_NONE;
        ctx_start      = 1'b0;
        ctx_clear      = 1'b0;
        bump           = 1'b0;
        pcmd           = '0;
        pcmd.ones      = ctx_ones;
        pcmd.ovf       = ovf_reg;
        fin_next       = fin_reg;
        ebit_next      = ebit_reg;
        first_next     = first_reg;
        ret_flush_next = ret_flush_reg;
        pending_next   = pending_reg;
        unique case (state_reg)
            bae_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rop       = bae_pkg::ROP_LOAD;
                    ctx_start = 1'b1;
                    fin_next  = final_bit;
                end
            end
            bae_pkg::ST_MUL:
                rop = bae_pkg::ROP_MUL;
            bae_pkg::ST_NARROW:
                rop = bae_pkg::ROP_NARROW;
            bae_pkg::ST_RENORM:
            begin
                unique case (rstat.rclass)
                    bae_pkg::RN_LOW, bae_pkg::RN_HIGH:
                    begin
                        rop            = bae_pkg::ROP_SHIFT;
                        ebit_next      = (rstat.rclass == bae_pkg::RN_HIGH);
                        first_next     = 1'b1;
                        ret_flush_next = 1'b0;
                    end
                    bae_pkg::RN_MID:
                    begin
                        rop  = bae_pkg::ROP_SHIFT;
                        bump = 1'b1;
                    end
                    bae_pkg::RN_DONE:
                    begin
                        // closing bit: 0 or 1 by the quarter mark, with one more follower
                        if (fin_reg)
                        begin
                            bump           = 1'b1;
                            ebit_next      = !rstat.below_quarter;
                            first_next     = 1'b1;
                            ret_flush_next = 1'b1;
                        end
                    end
                endcase
            end
            bae_pkg::ST_EMIT:
            begin
                if (pstat.emit_ok)
                begin
                    pcmd.emit = 1'b1;
                    pcmd.ebit = first_reg ? ebit_reg : !ebit_reg;
                    if (first_reg)
                        first_next = 1'b0;
                    else
                        pending_next = pending_reg - bae_pkg::PEND_W'(1);
                end
            end
            bae_pkg::ST_FLUSH:
                pcmd.flush = pstat.slot_free;
            bae_pkg::ST_STATUS:
            begin
                if (pstat.slot_free && !ctx_busy)
                begin
                    pcmd.status = 1'b1;
                    if (fin_reg)
                    begin
                        rop          = bae_pkg::ROP_CLEAR;
                        ctx_clear    = 1'b1;
                        pending_next = '0;
                    end
                end
            end
            default:
                in_ready = 1'b0;
        endcase
        if (bump && pending_reg < bae_pkg::PEND_LIMIT)
            pending_next = pending_reg + bae_pkg::PEND_W'(1);
    end

    always_comb
    begin
        ovf_next = ovf_reg;
        if (bump && pending_reg >= bae_pkg::PEND_LIMIT)
            ovf_next = 1'b1;
        if (pcmd.status && fin_reg)
            ovf_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bae_pkg::ST_IDLE;
            ctx_len_reg   <= '0;
            pending_reg   <= '0;
            ovf_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            ebit_reg      <= 1'b0;
            first_reg     <= 1'b0;
            ret_flush_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            ovf_reg       <= ovf_next;
            fin_reg       <= fin_next;
            ebit_reg      <= ebit_next;
            first_reg     <= first_next;
            ret_flush_reg <= ret_flush_next;
            if (cfg_we)
                ctx_len_reg <= cfg_wdata;
        end
    end

    bae_range_unit u_range (
        .clk    (clk),
        .rst_n  (rst_n),
        .rop    (rop),
        .bit_in (in_bit),
        .p0_in  (p0),
        .stat   (rstat)
    );

    bae_context u_context (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctx_len (ctx_len_reg),
        .start   (ctx_start && accept),
        .bit_in  (in_bit),
        .clear   (ctx_clear),
        .busy    (ctx_busy),
        .ones    (ctx_ones)
    );

    bae_packer u_packer (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (pcmd),
        .stat             (pstat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_byte          (is_byte),
        .out_byte         (out_byte),
        .ones_in_context  (ones_in_context),
        .pending_overflow (pending_overflow),
        .run_end          (run_end)
    );

endmodule
`default_nettype wire

// File: rtl/bae_checker.sv
// Port-level checks of the binary arithmetic encoder, bound to the top level.
`default_nettype none
module bae_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic                      is_byte,
    input wire logic [7:0]                out_byte,
    input wire logic [bae_pkg::CNT_W-1:0] ones_in_context,
    input wire logic                      pending_overflow,
    input wire logic                      run_end
);

    // hold a stalled record
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_byte)
            && $stable(run_end))
        else $error("output record changed while stalled");

    // byte records carry no status, status records carry no byte
    a_rec_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_byte && !run_end && ones_in_context == '0 && !pending_overflow)
            || (!is_byte && run_end && out_byte == '0))
        else $error("malformed output record");

    // a transaction keeps the encoder busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    a_ones_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_end |-> ones_in_context <= bae_pkg::CNT_W'(bae_pkg::CTX_MAX))
        else $error("context count out of range");

endmodule

bind binary_arithmetic_encoder bae_checker u_bae_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_byte          (is_byte),
    .out_byte         (out_byte),
    .ones_in_context  (ones_in_context),
    .pending_overflow (pending_overflow),
    .run_end          (run_end)
);
`default_nettype wire
